FILE: rtl/core/stq_pkg.sv
`default_nettype none

package stq_pkg;

    // Default number of timer slots
    localparam int CAPACITY_DEFAULT = 16;

    // Most expired entries popped by one tick
    localparam int MAX_RESULTS = 16;

    // Reset value of the tick interval register
    localparam logic [15:0] INTERVAL_RESET = 16'd5;

    // Request kinds on the input stream
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_EXTEND = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXPIRED   = 3'd1,
        ST_NONE      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // One stored timer
    typedef struct packed {
        logic [31:0] expiry;
        logic [15:0] conn;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_timer_expiry_queue_core.sv
// Sorted timer queue: holds up to CAPACITY (conn_id, expiry) timers in ascending
// expiry order inside one single-port-write, registered-read memory used as a ring.
// Input stream: s_tuser = request kind, s_tdata = conn_id and time_value. Add inserts
// after equal expiries (status full when no slot is free), extend adds three times
// tick_interval (saturating) and re-sorts, remove deletes the first matching id,
// tick pops up to MAX_RESULTS expired entries from the front.
// Output stream: one transfer per result, m_tlast on the final one of a request.
// Each request is handled to completion before the next is taken. Every memory
// step is a read, then a compare, a write back or both: add moves the entries
// after the insertion point up, remove and extend search from the front and close
// the gap (extend then re-inserts), and tick pops from the front until an
// unexpired entry or the end of the queue stops the walk. Results leave through a
// registered output. A stalled receiver holds the output register
// and the sequencer waits at its next result. The APB port sets tick_interval and
// must be written only while the queue is idle.
// Reset empties the queue at once (count and ring head cleared, no memory sweep)
// and sets tick_interval to 5.
`default_nettype none

module sorted_timer_expiry_queue_core #(
    parameter int CAPACITY = stq_pkg::CAPACITY_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // [15:0] conn_id, [47:16] time_value
    input  wire logic [1:0]  s_tuser,  // [1:0] req_type
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // [15:0] expired_id
    output logic [2:0]       m_tuser,  // [2:0] status
    output logic             m_tlast,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = $clog2(stq_pkg::MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        IDLE,
        INS_RD,
        INS_CHK,
        FIND_RD,
        FIND_CHK,
        DEL_RD,
        DEL_WR,
        TICK_RD,
        TICK_CHK,
        RESP
    } state_t;

    // Ring position of a logical offset from the head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW + 1)'(CAPACITY)) begin
            s = s - (AW + 1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [NW-1:0]         n_reg, n_next;
    stq_pkg::req_t         req_reg, req_next;
    logic [15:0]           id_reg, id_next;
    logic [31:0]           tv_reg, tv_next;
    stq_pkg::status_t      resp_status_reg, resp_status_next;
    logic [15:0]           resp_id_reg, resp_id_next;
    logic                  out_valid_reg, out_valid_next;
    stq_pkg::status_t      out_status_reg, out_status_next;
    logic [15:0]           out_id_reg, out_id_next;
    logic                  out_last_reg, out_last_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    stq_pkg::entry_t       mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    stq_pkg::entry_t       mem_rdata;

    logic [15:0]           tick_interval;
    logic [17:0]           ext_amount;
    logic [32:0]           ext_sum;
    logic [31:0]           ext_expiry;
    logic [CW-1:0]         idx_dec;
    logic [CW-1:0]         idx_inc;
    logic                  out_free;
    logic                  in_xfer;
    stq_pkg::entry_t       new_entry;

    stq_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .tick_interval (tick_interval)
    );

    stq_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign new_entry = '{expiry: tv_reg, conn: id_reg};

    // Extended expiry: add three intervals, saturate at all ones
    assign ext_amount = {1'b0, tick_interval, 1'b0} + {2'b00, tick_interval};
    assign ext_sum    = {1'b0, mem_rdata.expiry} + {15'd0, ext_amount};
    assign ext_expiry = ext_sum[32] ? 32'hFFFF_FFFF : ext_sum[31:0];

    // Sequencer: next values and memory accesses
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        req_next         = req_reg;
        id_next          = id_reg;
        tv_next          = tv_reg;
        resp_status_next = resp_status_reg;
        resp_id_next     = resp_id_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = new_entry;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        unique case (state_reg)
            IDLE: begin
                if (in_xfer) begin
                    req_next     = stq_pkg::req_t'(s_tuser);
                    id_next      = s_tdata[15:0];
                    tv_next      = s_tdata[47:16];
                    resp_id_next = 16'd0;
                    n_next       = '0;
                    unique case (stq_pkg::req_t'(s_tuser))
                        stq_pkg::REQ_ADD: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                resp_status_next = stq_pkg::ST_FULL;
                                state_next       = RESP;
                            end else begin
                                idx_next   = count_reg;
                                state_next = INS_RD;
                            end
                        end
                        stq_pkg::REQ_EXTEND, stq_pkg::REQ_REMOVE: begin
                            if (count_reg == '0) begin
                                resp_status_next = stq_pkg::ST_NOT_FOUND;
                                state_next       = RESP;
                            end else begin
                                idx_next   = '0;
                                state_next = FIND_RD;
                            end
                        end
                        stq_pkg::REQ_TICK: begin
                            if (count_reg == '0) begin
                                resp_status_next = stq_pkg::ST_NONE;
                                state_next       = RESP;
                            end else begin
                                state_next = TICK_RD;
                            end
                        end
                        default: begin
                            state_next = IDLE;
                        end
                    endcase
                end
            end

            // Walk back from the hole, moving later entries up by one
            INS_RD: begin
                if (idx_reg == '0) begin
                    mem_we           = 1'b1;
                    mem_waddr        = head_reg;
                    mem_wdata        = new_entry;
                    count_next       = count_reg + 1'b1;
                    resp_status_next = stq_pkg::ST_OK;
                    state_next       = RESP;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(head_reg, idx_dec[AW-1:0]);
                    state_next = INS_CHK;
                end
            end

            INS_CHK: begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg[AW-1:0]);
                if (mem_rdata.expiry <= tv_reg) begin
                    mem_wdata        = new_entry;
                    count_next       = count_reg + 1'b1;
                    resp_status_next = stq_pkg::ST_OK;
                    state_next       = RESP;
                end else begin
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_dec;
                    state_next = INS_RD;
                end
            end

            // Search the first entry with a matching id
            FIND_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = phys(head_reg, idx_reg[AW-1:0]);
                state_next = FIND_CHK;
            end

            FIND_CHK: begin
                if (mem_rdata.conn == id_reg) begin
                    if (req_reg == stq_pkg::REQ_EXTEND) begin
                        tv_next = ext_expiry;
                    end
                    state_next = DEL_RD;
                end else if (idx_inc == count_reg) begin
                    resp_status_next = stq_pkg::ST_NOT_FOUND;
                    state_next       = RESP;
                end else begin
                    idx_next   = idx_inc;
                    state_next = FIND_RD;
                end
            end

            // Close the gap by moving later entries down by one
            DEL_RD: begin
                if (idx_inc == count_reg) begin
                    count_next = count_reg - 1'b1;
                    if (req_reg == stq_pkg::REQ_REMOVE) begin
                        resp_status_next = stq_pkg::ST_OK;
                        state_next       = RESP;
                    end else begin
                        idx_next   = count_reg - 1'b1;
                        state_next = INS_RD;
                    end
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(head_reg, idx_inc[AW-1:0]);
                    state_next = DEL_WR;
                end
            end

            DEL_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, idx_reg[AW-1:0]);
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = DEL_RD;
            end

            // Pop expired entries from the head
            TICK_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                state_next = TICK_CHK;
            end

            TICK_CHK: begin
                if (out_free) begin
                    if (mem_rdata.expiry <= tv_reg) begin
                        head_next        = phys(head_reg, AW'(1));
                        count_next       = count_reg - 1'b1;
                        n_next           = n_reg + 1'b1;
                        // Release the previous pop, now known not to be the last
                        if (n_reg != '0) begin
                            out_valid_next  = 1'b1;
                            out_status_next = stq_pkg::ST_EXPIRED;
                            out_id_next     = resp_id_reg;
                            out_last_next   = 1'b0;
                        end
                        resp_id_next     = mem_rdata.conn;
                        resp_status_next = stq_pkg::ST_EXPIRED;
                        if ((n_reg + 1'b1 == NW'(stq_pkg::MAX_RESULTS))
                                || (count_reg == CW'(1))) begin
                            state_next = RESP;
                        end else begin
                            state_next = TICK_RD;
                        end
                    end else begin
                        if (n_reg == '0) begin
                            resp_status_next = stq_pkg::ST_NONE;
                            resp_id_next     = 16'd0;
                        end
                        state_next = RESP;
                    end
                end
            end

            // Final result of the request
            RESP: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_status_reg;
                    out_id_next     = resp_id_reg;
                    out_last_next   = 1'b1;
                    state_next      = IDLE;
                end
            end

            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
        idx_reg         <= idx_next;
        req_reg         <= req_next;
        id_reg          <= id_next;
        tv_reg          <= tv_next;
        resp_status_reg <= resp_status_next;
        resp_id_reg     <= resp_id_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stq_mem.sv
`default_nettype none

module stq_mem #(
    parameter int DEPTH = stq_pkg::CAPACITY_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire stq_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output stq_pkg::entry_t      rdata
);

    stq_pkg::entry_t mem [DEPTH];
    stq_pkg::entry_t rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stq_cfg.sv
`default_nettype none

module stq_cfg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [15:0]      tick_interval
);

    // Word index of the tick interval register
    localparam logic REG_TICK_INTERVAL = 1'b0;

    logic [15:0] interval_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Update the interval on a write transfer to its address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= stq_pkg::INTERVAL_RESET;
        end else if (wr_en && (paddr[2] == REG_TICK_INTERVAL)) begin
            interval_reg <= pwdata[15:0];
        end
    end

    // Read back
    always_comb begin
        if (paddr[2] == REG_TICK_INTERVAL) begin
            prdata = {16'd0, interval_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    assign tick_interval = interval_reg;

endmodule

`default_nettype wire
